FILE: hdl/fqkr_pkg.sv
package fqkr_pkg;

    localparam int ValueW = 31;
    localparam int SecW   = 32;
    localparam int UsecW  = 20;
    localparam int ReqW   = 2;
    localparam int PosW   = 6;
    localparam int StatW  = 2;
    localparam int CapW   = 7;
    localparam int OccW   = 7;

    localparam logic [ReqW-1:0] REQ_PUSH    = 2'd0;
    localparam logic [ReqW-1:0] REQ_POP     = 2'd1;
    localparam logic [ReqW-1:0] REQ_DEL_VAL = 2'd2;
    localparam logic [ReqW-1:0] REQ_DEL_IDX = 2'd3;

    localparam logic [StatW-1:0] ST_OK    = 2'd0;
    localparam logic [StatW-1:0] ST_MISS  = 2'd1;
    localparam logic [StatW-1:0] ST_FULL  = 2'd2;
    localparam logic [StatW-1:0] ST_RANGE = 2'd3;

    localparam logic [CapW-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic [SecW-1:0]   sec;
        logic [UsecW-1:0]  usec;
    } entry_t;

endpackage

FILE: hdl/fqkr_store.sv
module fqkr_store #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  fqkr_pkg::entry_t           wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output fqkr_pkg::entry_t           rdata
);
    import fqkr_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/fifo_queue_with_keyed_removal_core.sv
// Channel | Signals                                              | Direction
// cfg     | cfg_valid, cfg_ready, cfg_data                       | in
// in      | in_valid, in_ready, req_type, value, arrival_sec,    | in
//         | arrival_usec, position                               |
// out     | out_valid, out_ready, status, result_value,          | out
//         | result_sec, result_usec, occupancy                   |
//
// One transaction at a time; a result sits in an output register so the next
// transaction is taken while it waits. Push and requests rejected up front go
// straight to S_DONE. Pop and removals walk the entry memory (one read port,
// registered data): remove-by-value scans from the newest entry, then the
// entries behind the removed one move down one slot per cycle.
// rst_n clears count, capacity (to 64) and handshake state; no clearing pass.
module fifo_queue_with_keyed_removal_core #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fqkr_pkg::CapW-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fqkr_pkg::ReqW-1:0]     req_type,
    input  logic [fqkr_pkg::ValueW-1:0]   value,
    input  logic [fqkr_pkg::SecW-1:0]     arrival_sec,
    input  logic [fqkr_pkg::UsecW-1:0]    arrival_usec,
    input  logic [fqkr_pkg::PosW-1:0]     position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fqkr_pkg::StatW-1:0]    status,
    output logic [fqkr_pkg::ValueW-1:0]   result_value,
    output logic [fqkr_pkg::SecW-1:0]     result_sec,
    output logic [fqkr_pkg::UsecW-1:0]    result_usec,
    output logic [fqkr_pkg::OccW-1:0]     occupancy
);
    import fqkr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > OccW) ? CW : OccW;
    localparam int XW = LW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_GRAB  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CapW-1:0]   cap_reg, cap_next;
    logic              out_valid_reg, out_valid_next;
    logic              scan_left_reg, scan_left_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [AW-1:0]     chk_idx_reg, chk_idx_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [ValueW-1:0] key_reg, key_next;
    logic [ReqW-1:0]   req_reg, req_next;
    logic [StatW-1:0]  pend_status_reg, pend_status_next;
    entry_t            pend_reg, pend_next;
    logic [StatW-1:0]  out_status_reg, out_status_next;
    entry_t            out_reg, out_next;
    logic [OccW-1:0]   out_occ_reg, out_occ_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    entry_t            mem_wdata;
    logic [AW-1:0]     mem_raddr;
    entry_t            mem_rdata;

    logic [LW-1:0]     cnt_l;
    logic [LW-1:0]     idx_l;
    logic [XW-1:0]     cnt_x;
    logic [XW-1:0]     ptr_p1;
    logic [XW-1:0]     ptr_p2;
    logic              full;

    fqkr_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cnt_l  = LW'(cnt_reg);
    assign idx_l  = cnt_l - LW'(1) - LW'(position);
    assign cnt_x  = XW'(cnt_reg);
    assign ptr_p1 = XW'(ptr_reg) + XW'(1);
    assign ptr_p2 = XW'(ptr_reg) + XW'(2);
    assign full   = (cnt_l >= LW'(cap_reg)) || (cnt_reg == CW'(DEPTH));

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        cap_next         = cap_reg;
        out_valid_next   = out_valid_reg;
        scan_left_next   = scan_left_reg;
        chk_valid_next   = chk_valid_reg;
        chk_idx_next     = chk_idx_reg;
        ptr_next         = ptr_reg;
        key_next         = key_reg;
        req_next         = req_reg;
        pend_status_next = pend_status_reg;
        pend_next        = pend_reg;
        out_status_next  = out_status_reg;
        out_next         = out_reg;
        out_occ_next     = out_occ_reg;

        mem_we    = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_wdata = '{value: value, sec: arrival_sec, usec: arrival_usec};
        mem_raddr = ptr_reg;

        if (cfg_valid)
        begin
            cap_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next         = req_type;
                    key_next         = value;
                    pend_status_next = ST_OK;
                    pend_next        = '0;
                    state_next       = S_DONE;
                    unique case (req_type)
                        REQ_PUSH:
                        begin
                            if (full)
                            begin
                                pend_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                cnt_next        = cnt_reg + CW'(1);
                                pend_next.value = value;
                            end
                        end
                        REQ_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pend_status_next = ST_MISS;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_FETCH;
                            end
                        end
                        REQ_DEL_VAL:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pend_status_next = ST_MISS;
                            end
                            else
                            begin
                                ptr_next       = AW'(cnt_l - LW'(1));
                                scan_left_next = 1'b1;
                                chk_valid_next = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        REQ_DEL_IDX:
                        begin
                            if (LW'(position) >= cnt_l)
                            begin
                                pend_status_next = ST_RANGE;
                            end
                            else
                            begin
                                ptr_next   = idx_l[AW-1:0];
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                state_next = S_GRAB;
            end
            S_GRAB:
            begin
                pend_next.value = mem_rdata.value;
                if (req_reg == REQ_POP)
                begin
                    pend_next.sec  = mem_rdata.sec;
                    pend_next.usec = mem_rdata.usec;
                end
                if (ptr_p1 < cnt_x)
                begin
                    mem_raddr  = ptr_p1[AW-1:0];
                    state_next = S_SHIFT;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                ptr_next  = ptr_p1[AW-1:0];
                if (ptr_p2 < cnt_x)
                begin
                    mem_raddr = ptr_p2[AW-1:0];
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (chk_valid_reg && (mem_rdata.value == key_reg))
                begin
                    ptr_next   = chk_idx_reg;
                    state_next = S_FETCH;
                end
                else if (scan_left_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = ptr_reg;
                    if (ptr_reg == '0)
                    begin
                        scan_left_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - AW'(1);
                    end
                end
                else
                begin
                    pend_status_next = ST_MISS;
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_next        = pend_reg;
                    out_occ_next    = cnt_l[OccW-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
            scan_left_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
            scan_left_reg <= scan_left_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg     <= chk_idx_next;
        ptr_reg         <= ptr_next;
        key_reg         <= key_next;
        req_reg         <= req_next;
        pend_status_reg <= pend_status_next;
        pend_reg        <= pend_next;
        out_status_reg  <= out_status_next;
        out_reg         <= out_next;
        out_occ_reg     <= out_occ_next;
    end

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_value = out_reg.value;
    assign result_sec   = out_reg.sec;
    assign result_usec  = out_reg.usec;
    assign occupancy    = out_occ_reg;

endmodule
